// ----- hw/rtl/eedp_pkg.sv -----
// eedp_pkg: shared types for the extended event descriptor parser
// holds the parse phase and field kind codes and the result struct
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package eedp_pkg;

	localparam int unsigned LangLen = 3;

	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_LENGTH    = 4'd1,
		PH_NUMBERS   = 4'd2,
		PH_LANG      = 4'd3,
		PH_ITEMS_LEN = 4'd4,
		PH_DESC_LEN  = 4'd5,
		PH_DESC_CHAR = 4'd6,
		PH_ITEM_LEN  = 4'd7,
		PH_ITEM_CHAR = 4'd8,
		PH_TEXT_LEN  = 4'd9,
		PH_TEXT_CHAR = 4'd10
	} phase_t;

	typedef enum logic [3:0] {
		FK_IGNORED   = 4'd0,
		FK_TAG       = 4'd1,
		FK_LENGTH    = 4'd2,
		FK_NUMBERS   = 4'd3,
		FK_LANG      = 4'd4,
		FK_ITEMS_LEN = 4'd5,
		FK_DESC_LEN  = 4'd6,
		FK_DESC_CHAR = 4'd7,
		FK_ITEM_LEN  = 4'd8,
		FK_ITEM_CHAR = 4'd9,
		FK_TEXT_LEN  = 4'd10,
		FK_TEXT_CHAR = 4'd11
	} kind_t;

	typedef struct packed {
		logic [7:0] data;
		logic       start;
	} in_beat_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] value;
		logic [7:0] offset;
		logic [7:0] index;
		logic [3:0] desc_num;
		logic [3:0] last_num;
		logic       mismatch;
		logic       done;
	} res_t;

endpackage
`default_nettype wire

// ----- hw/rtl/eedp_in_stage.sv -----
// eedp_in_stage: input register for descriptor bytes
// depends on eedp_pkg
`timescale 1ns / 1ps
`default_nettype none
module eedp_in_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire eedp_pkg::in_beat_t beat,
	input  wire logic              adv,
	output logic                   valid_s1,
	output eedp_pkg::in_beat_t     beat_s1
);
	import eedp_pkg::*;

	logic take;

	assign in_stall = valid_s1 && !adv;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			beat_s1 <= beat;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/eedp_parser.sv -----
// eedp_parser: parse state registers and byte classification logic
// state moves when the registered beat is passed to the result register
// depends on eedp_pkg
`timescale 1ns / 1ps
`default_nettype none
module eedp_parser (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               fire,
	input  wire eedp_pkg::in_beat_t beat_s1,
	output eedp_pkg::res_t          res
);
	import eedp_pkg::*;

	phase_t     phase_q, phase_n;
	logic [7:0] frem_q, frem_n;
	logic [7:0] foff_q, foff_n;
	logic [7:0] irem_q, irem_n;
	logic [7:0] icnt_q, icnt_n;
	logic [7:0] nums_q, nums_n;
	logic       mm_q, mm_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			frem_q  <= '0;
			foff_q  <= '0;
			irem_q  <= '0;
			icnt_q  <= '0;
			nums_q  <= '0;
			mm_q    <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_n;
			frem_q  <= frem_n;
			foff_q  <= foff_n;
			irem_q  <= irem_n;
			icnt_q  <= icnt_n;
			nums_q  <= nums_n;
			mm_q    <= mm_n;
		end
	end

	always_comb begin
		logic [7:0] b;
		logic [7:0] irem_dec;
		logic [7:0] frem_dec;
		logic       rg_use;
		logic       rg_complete;
		phase_t     rg_next;
		kind_t      kind;
		logic [7:0] off;
		logic [7:0] idx;
		logic       done;
		logic       active;

		b        = beat_s1.data;
		irem_dec = (irem_q != 8'd0) ? irem_q - 8'd1 : irem_q;
		frem_dec = (frem_q != 8'd0) ? frem_q - 8'd1 : frem_q;

		phase_n     = phase_q;
		frem_n      = frem_q;
		foff_n      = foff_q;
		irem_n      = irem_q;
		icnt_n      = icnt_q;
		nums_n      = nums_q;
		mm_n        = mm_q;
		rg_use      = 1'b0;
		rg_complete = 1'b0;
		rg_next     = PH_IDLE;
		kind        = FK_IGNORED;
		off         = '0;
		idx         = icnt_q;
		done        = 1'b0;
		active      = 1'b1;

		if (beat_s1.start) begin
			phase_n = PH_LENGTH;
			frem_n  = '0;
			foff_n  = '0;
			irem_n  = '0;
			icnt_n  = '0;
			nums_n  = '0;
			mm_n    = 1'b0;
			idx     = '0;
			kind    = FK_TAG;
		end else begin
			case (phase_q)
				PH_LENGTH: begin
					kind    = FK_LENGTH;
					phase_n = PH_NUMBERS;
				end
				PH_NUMBERS: begin
					kind    = FK_NUMBERS;
					nums_n  = b;
					foff_n  = '0;
					phase_n = PH_LANG;
				end
				PH_LANG: begin
					kind   = FK_LANG;
					off    = foff_q;
					foff_n = foff_q + 8'd1;
					if (foff_n >= 8'(LangLen)) begin
						phase_n = PH_ITEMS_LEN;
					end
				end
				PH_ITEMS_LEN: begin
					kind    = FK_ITEMS_LEN;
					irem_n  = b;
					phase_n = (b != 8'd0) ? PH_DESC_LEN : PH_TEXT_LEN;
				end
				PH_DESC_LEN: begin
					kind    = FK_DESC_LEN;
					irem_n  = irem_dec;
					frem_n  = b;
					foff_n  = '0;
					rg_use  = 1'b1;
					rg_next = (b != 8'd0) ? PH_DESC_CHAR : PH_ITEM_LEN;
				end
				PH_DESC_CHAR: begin
					kind    = FK_DESC_CHAR;
					off     = foff_q;
					irem_n  = irem_dec;
					frem_n  = frem_dec;
					foff_n  = foff_q + 8'd1;
					rg_use  = 1'b1;
					rg_next = (frem_dec != 8'd0) ? PH_DESC_CHAR : PH_ITEM_LEN;
				end
				PH_ITEM_LEN: begin
					kind        = FK_ITEM_LEN;
					irem_n      = irem_dec;
					frem_n      = b;
					foff_n      = '0;
					rg_use      = 1'b1;
					rg_complete = (b == 8'd0);
					rg_next     = PH_ITEM_CHAR;
				end
				PH_ITEM_CHAR: begin
					kind        = FK_ITEM_CHAR;
					off         = foff_q;
					irem_n      = irem_dec;
					frem_n      = frem_dec;
					foff_n      = foff_q + 8'd1;
					rg_use      = 1'b1;
					rg_complete = (frem_dec == 8'd0);
					rg_next     = PH_ITEM_CHAR;
				end
				PH_TEXT_LEN: begin
					kind   = FK_TEXT_LEN;
					frem_n = b;
					foff_n = '0;
					if (b == 8'd0) begin
						done    = 1'b1;
						phase_n = PH_IDLE;
					end else begin
						phase_n = PH_TEXT_CHAR;
					end
				end
				PH_TEXT_CHAR: begin
					kind   = FK_TEXT_CHAR;
					off    = foff_q;
					frem_n = frem_dec;
					foff_n = foff_q + 8'd1;
					if (frem_dec == 8'd0) begin
						done    = 1'b1;
						phase_n = PH_IDLE;
					end
				end
				default: begin
					active  = 1'b0;
					phase_n = PH_IDLE;
				end
			endcase

			// end of item or end of item region
			if (rg_use) begin
				if (rg_complete) begin
					icnt_n  = icnt_q + 8'd1;
					phase_n = (irem_dec != 8'd0) ? PH_DESC_LEN : PH_TEXT_LEN;
				end else if (irem_dec == 8'd0) begin
					icnt_n  = icnt_q + 8'd1;
					mm_n    = 1'b1;
					phase_n = PH_TEXT_LEN;
				end else begin
					phase_n = rg_next;
				end
			end
		end

		res.kind  = kind;
		res.value = b;
		if (active) begin
			res.offset   = off;
			res.index    = idx;
			res.desc_num = nums_n[7:4];
			res.last_num = nums_n[3:0];
			res.mismatch = mm_n;
			res.done     = done;
		end else begin
			res.offset   = '0;
			res.index    = '0;
			res.desc_num = '0;
			res.last_num = '0;
			res.mismatch = 1'b0;
			res.done     = 1'b0;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/eedp_out_stage.sv -----
// eedp_out_stage: result register toward the output channel
// depends on eedp_pkg
`timescale 1ns / 1ps
`default_nettype none
module eedp_out_stage (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           valid_s1,
	input  wire eedp_pkg::res_t res,
	output logic                adv,
	output logic                out_valid,
	input  wire logic           out_stall,
	output eedp_pkg::res_t      res_s2
);
	import eedp_pkg::*;

	assign adv = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			res_s2 <= res;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/extended_event_descriptor_parser_core.sv -----
// extended_event_descriptor_parser_core: classifies extended event descriptor bytes
// instantiates eedp_in_stage, eedp_parser and eedp_out_stage; depends on eedp_pkg
//
//   channel | valid     | stall     | payload
//   in      | in_valid  | in_stall  | data_byte, start_req
//   out     | out_valid | out_stall | field_kind .. done_res
//
// one beat in, one beat out; a beat is accepted every cycle when out is not stalled
// each beat goes through the input register, then classification into the result register
// the parse state advances when a beat moves from the input register to the result register
// arst_n clears the valid flags and the parse state to idle
// out_stall holds a valid result and a full input register; in_stall rises only when it is full and held
`timescale 1ns / 1ps
`default_nettype none
module extended_event_descriptor_parser_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       start_req,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [3:0]      field_kind,
	output logic [7:0]      byte_value,
	output logic [7:0]      char_offset,
	output logic [7:0]      item_index,
	output logic [3:0]      desc_number,
	output logic [3:0]      last_desc_number,
	output logic            length_mismatch,
	output logic            done_res
);
	import eedp_pkg::*;

	in_beat_t beat, beat_s1;
	logic     valid_s1;
	logic     adv;
	res_t     res, res_s2;

	assign beat.data  = data_byte;
	assign beat.start = start_req;

	eedp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.beat     (beat),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.beat_s1  (beat_s1)
	);

	eedp_parser u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (valid_s1 && adv),
		.beat_s1 (beat_s1),
		.res     (res)
	);

	eedp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.res       (res),
		.adv       (adv),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_s2    (res_s2)
	);

	assign field_kind       = res_s2.kind;
	assign byte_value       = res_s2.value;
	assign char_offset      = res_s2.offset;
	assign item_index       = res_s2.index;
	assign desc_number      = res_s2.desc_num;
	assign last_desc_number = res_s2.last_num;
	assign length_mismatch  = res_s2.mismatch;
	assign done_res         = res_s2.done;

	a_done_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> field_kind == FK_TEXT_LEN || field_kind == FK_TEXT_CHAR)
		else $error("done on a non-text beat");

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && field_kind == FK_IGNORED |->
		char_offset == 8'd0 && item_index == 8'd0 && !length_mismatch && !done_res)
		else $error("ignored beat carries parse fields");

	a_tag_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && field_kind == FK_TAG |->
		item_index == 8'd0 && !length_mismatch && desc_number == 4'd0 && !done_res)
		else $error("tag beat does not restart the parse");

	a_offset_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && char_offset != 8'd0 |->
		field_kind == FK_LANG || field_kind == FK_DESC_CHAR ||
		field_kind == FK_ITEM_CHAR || field_kind == FK_TEXT_CHAR)
		else $error("offset on a non-string beat");

endmodule
`default_nettype wire
